### rtl/core/frame_bitmap_allocator_macros.svh
// assertion macros used by the frame bitmap allocator checker
`ifndef FRAME_BITMAP_ALLOCATOR_MACROS_SVH
`define FRAME_BITMAP_ALLOCATOR_MACROS_SVH

// same-cycle implication under reset
`define FBA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame_bitmap_allocator check failed");

// next-cycle implication under reset
`define FBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame_bitmap_allocator check failed");

`endif

### rtl/core/fba_pkg.sv
// shared types and constants of the frame bitmap allocator
package fba_pkg;

    localparam int FRAME_W     = 14;
    localparam int COUNT_W     = 15;
    localparam int STATUS_W    = 3;
    localparam int FRAME_LIMIT = 16384;

    localparam logic [COUNT_W-1:0] CFG_RESET = COUNT_W'(16384);

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ALLOCATED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HAD_FRAME     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_FRAMES = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FREED         = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTHING       = 3'd4;

    typedef struct packed {
        logic               mode;
        logic [FRAME_W-1:0] current_frame;
        logic               kernel_page;
        logic               writeable;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                present_bit;
        logic                rw_bit;
        logic                user_bit;
        logic [FRAME_W-1:0]  frame_number;
    } rsp_t;

endpackage

### rtl/core/fba_if.sv
// request, response and configuration channel interfaces
interface fba_req_if;
    logic          valid;
    logic          ready;
    fba_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fba_rsp_if;
    logic          valid;
    logic          ready;
    fba_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fba_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [fba_pkg::COUNT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/fba_ram.sv
// generic single-write, single-read ram with registered read data
module fba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/fba_find.sv
// lowest free frame search within one bitmap word, bounded by the usable count
module fba_find #(
    parameter int WB = 32,
    localparam int BW = $clog2(WB)
) (
    input  logic [WB-1:0]               word,
    input  logic [fba_pkg::COUNT_W-1:0] base,
    input  logic [fba_pkg::COUNT_W-1:0] limit,
    output logic                        found,
    output logic [BW-1:0]               idx
);

    logic [fba_pkg::COUNT_W-1:0] span;

    assign span = limit - base;

    // scan high to low so the lowest free bit wins
    always_comb
    begin
        found = 1'b0;
        idx   = '0;
        for (int i = WB - 1; i >= 0; i--)
        begin
            if (!word[i] && (fba_pkg::COUNT_W'(i) < span))
            begin
                found = 1'b1;
                idx   = BW'(i);
            end
        end
    end

endmodule

### rtl/core/frame_bitmap_allocator.sv
// First-fit page frame allocator over a used-frame bitmap held in ram.
// Channels: req (mode, current_frame, kernel_page, writeable), rsp (status,
// flags, frame_number) and cfg (usable frame count), all valid/ready; a word
// moves at a clock edge where valid and ready are both high. cfg is always
// ready; the user must write it only while the block is idle, as the block
// itself does not enforce this. One response word per request word.
// Allocate with a nonzero frame, free of frame zero and allocate with no
// usable frames go straight to response staging. Free of a frame steps
// through reciprocal divide, ram read, ram write and response staging.
// Allocation scans the bitmap one word per cycle through the single ram read
// port and the one search unit. req is ready only when no request is in
// flight; a finished response sits in the output register, so the next
// request is taken while rsp stalls. A stalled rsp holds its word and keeps
// a finished request from completing. After reset the bitmap ram is cleared
// one word per cycle, through every word, before req goes ready.
module frame_bitmap_allocator #(
    parameter int TOTAL_FRAMES = 16384,
    parameter int WORD_BITS    = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    fba_req_if.sink        req,
    fba_rsp_if.source      rsp,
    fba_cfg_if.sink        cfg
);

    localparam int WORDS  = (TOTAL_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BW     = $clog2(WORD_BITS);
    localparam int LIMIT  = (TOTAL_FRAMES < fba_pkg::FRAME_LIMIT) ? TOTAL_FRAMES
                                                                 : fba_pkg::FRAME_LIMIT;
    localparam int DIV_SH = 27;
    localparam int RCP_W  = 26;
    localparam int PROD_W = fba_pkg::FRAME_W + RCP_W;
    localparam logic [RCP_W-1:0] RECIP = RCP_W'((1 << DIV_SH) / WORD_BITS + 1);
    localparam logic [fba_pkg::COUNT_W-1:0] LIMIT_C = fba_pkg::COUNT_W'(LIMIT);
    localparam logic [fba_pkg::COUNT_W-1:0] STEP_C  = fba_pkg::COUNT_W'(WORD_BITS);
    localparam logic [fba_pkg::FRAME_W-1:0] WB_F    = fba_pkg::FRAME_W'(WORD_BITS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(WORDS - 1);

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_FREE_Q  = 3'd3;
    localparam logic [2:0] S_FREE_RD = 3'd4;
    localparam logic [2:0] S_FREE_WR = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    // control state
    logic [2:0]                  state_reg, state_next;
    logic [AW-1:0]               clr_addr_reg, clr_addr_next;
    logic [fba_pkg::COUNT_W-1:0] cfg_reg, cfg_next;
    logic                        pend_valid_reg, pend_valid_next;
    logic                        out_valid_reg, out_valid_next;

    // payload state
    logic [fba_pkg::FRAME_W-1:0] cur_reg, cur_next;
    logic                        kern_reg, kern_next;
    logic                        wr_reg, wr_next;
    logic [fba_pkg::COUNT_W-1:0] n_reg, n_next;
    logic [fba_pkg::COUNT_W-1:0] issue_base_reg, issue_base_next;
    logic [AW-1:0]               issue_addr_reg, issue_addr_next;
    logic [fba_pkg::COUNT_W-1:0] pend_base_reg, pend_base_next;
    logic [AW-1:0]               pend_addr_reg, pend_addr_next;
    logic [fba_pkg::FRAME_W-1:0] q_reg, q_next;
    logic [BW-1:0]               bit_reg, bit_next;
    fba_pkg::rsp_t               res_reg, res_next;
    fba_pkg::rsp_t               out_reg, out_next;

    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [WORD_BITS-1:0]        mem_wdata;
    logic [AW-1:0]               mem_raddr;
    logic [WORD_BITS-1:0]        mem_rdata;

    logic                        find_found;
    logic [BW-1:0]               find_idx;
    logic                        issue_more;
    logic [fba_pkg::COUNT_W-1:0] usable;
    logic [PROD_W-1:0]           prod;
    logic [fba_pkg::FRAME_W-1:0] q_times_wb;
    logic                        free_ok;
    logic                        req_fire;
    logic                        out_load;

    fba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS)
    ) u_bitmap (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    fba_find #(
        .WB (WORD_BITS)
    ) u_find (
        .word  (mem_rdata),
        .base  (pend_base_reg),
        .limit (n_reg),
        .found (find_found),
        .idx   (find_idx)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    assign req_fire   = req.valid && req.ready;
    assign usable     = (cfg_reg < LIMIT_C) ? cfg_reg : LIMIT_C;
    assign issue_more = (issue_base_reg < n_reg);
    // floor(cur / WORD_BITS) by reciprocal, exact for 14-bit frames
    assign prod       = PROD_W'(cur_reg) * PROD_W'(RECIP);
    assign q_times_wb = q_reg * WB_F;
    assign free_ok    = (32'(cur_reg) < 32'(TOTAL_FRAMES));
    assign mem_raddr  = (state_reg == S_FREE_RD) ? AW'(q_reg) : issue_addr_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        cfg_next        = cfg_reg;
        pend_valid_next = pend_valid_reg;
        cur_next        = cur_reg;
        kern_next       = kern_reg;
        wr_next         = wr_reg;
        n_next          = n_reg;
        issue_base_next = issue_base_reg;
        issue_addr_next = issue_addr_reg;
        pend_base_next  = pend_base_reg;
        pend_addr_next  = pend_addr_reg;
        q_next          = q_reg;
        bit_next        = bit_reg;
        res_next        = res_reg;
        mem_we          = 1'b0;
        mem_waddr       = clr_addr_reg;
        mem_wdata       = '0;
        out_load        = 1'b0;

        if (cfg.valid && cfg.ready)
        begin
            cfg_next = cfg.data;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we        = 1'b1;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    cur_next        = req.data.current_frame;
                    kern_next       = req.data.kernel_page;
                    wr_next         = req.data.writeable;
                    n_next          = usable;
                    issue_base_next = '0;
                    issue_addr_next = '0;
                    pend_valid_next = 1'b0;
                    res_next        = '0;
                    if (req.data.current_frame != '0)
                    begin
                        if (req.data.mode == fba_pkg::MODE_ALLOC)
                        begin
                            res_next.status       = fba_pkg::ST_HAD_FRAME;
                            res_next.frame_number = req.data.current_frame;
                            state_next            = S_DONE;
                        end
                        else
                        begin
                            res_next.status = fba_pkg::ST_FREED;
                            state_next      = S_FREE_Q;
                        end
                    end
                    else if (req.data.mode == fba_pkg::MODE_FREE)
                    begin
                        res_next.status = fba_pkg::ST_NOTHING;
                        state_next      = S_DONE;
                    end
                    else if (usable == '0)
                    begin
                        res_next.status = fba_pkg::ST_OUT_OF_FRAMES;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // read word k while searching word k-1
                pend_valid_next = issue_more;
                pend_base_next  = issue_base_reg;
                pend_addr_next  = issue_addr_reg;
                if (issue_more)
                begin
                    issue_base_next = issue_base_reg + STEP_C;
                    issue_addr_next = issue_addr_reg + AW'(1);
                end
                if (pend_valid_reg && find_found)
                begin
                    mem_we                = 1'b1;
                    mem_waddr             = pend_addr_reg;
                    mem_wdata             = mem_rdata | (WORD_BITS'(1) << find_idx);
                    res_next.status       = fba_pkg::ST_ALLOCATED;
                    res_next.present_bit  = 1'b1;
                    res_next.rw_bit       = wr_reg;
                    res_next.user_bit     = !kern_reg;
                    res_next.frame_number = fba_pkg::FRAME_W'(pend_base_reg
                                            + fba_pkg::COUNT_W'(find_idx));
                    state_next            = S_DONE;
                end
                else if (!pend_valid_reg && !issue_more)
                begin
                    res_next.status = fba_pkg::ST_OUT_OF_FRAMES;
                    state_next      = S_DONE;
                end
            end
            S_FREE_Q:
            begin
                q_next     = fba_pkg::FRAME_W'(prod >> DIV_SH);
                state_next = S_FREE_RD;
            end
            S_FREE_RD:
            begin
                bit_next   = BW'(cur_reg - q_times_wb);
                state_next = S_FREE_WR;
            end
            S_FREE_WR:
            begin
                mem_we     = free_ok;
                mem_waddr  = AW'(q_reg);
                mem_wdata  = mem_rdata & ~(WORD_BITS'(1) << bit_reg);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !rsp.ready);
    assign out_next       = out_load ? res_reg : out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            cfg_reg        <= fba_pkg::CFG_RESET;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            cfg_reg        <= cfg_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        kern_reg       <= kern_next;
        wr_reg         <= wr_next;
        n_reg          <= n_next;
        issue_base_reg <= issue_base_next;
        issue_addr_reg <= issue_addr_next;
        pend_base_reg  <= pend_base_next;
        pend_addr_reg  <= pend_addr_next;
        q_reg          <= q_next;
        bit_reg        <= bit_next;
        res_reg        <= res_next;
        out_reg        <= out_next;
    end

endmodule

### rtl/core/fba_checker.sv
// port-level checks for the frame bitmap allocator and their binding
`include "frame_bitmap_allocator_macros.svh"

module fba_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [fba_pkg::STATUS_W-1:0] status,
    input logic                         present_bit,
    input logic                         rw_bit,
    input logic                         user_bit,
    input logic [fba_pkg::FRAME_W-1:0]  frame_number
);

    // a stalled response word stays offered
    `FBA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)

    // one request in flight at a time
    `FBA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_valid && req_ready, !req_ready)

    // entry flags only on a successful allocation, and then present is set
    `FBA_ASSERT_IMPLY(a_flags, clk, rst_n, rsp_valid, (status == fba_pkg::ST_ALLOCATED) ? present_bit : (!present_bit && !rw_bit && !user_bit))

    // no frame reported for out of frames, freed or nothing to free
    `FBA_ASSERT_IMPLY(a_zero_frame, clk, rst_n, rsp_valid && (status == fba_pkg::ST_OUT_OF_FRAMES || status == fba_pkg::ST_FREED || status == fba_pkg::ST_NOTHING), frame_number == '0)

endmodule

bind frame_bitmap_allocator fba_checker u_fba_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .status       (rsp.data.status),
    .present_bit  (rsp.data.present_bit),
    .rw_bit       (rsp.data.rw_bit),
    .user_bit     (rsp.data.user_bit),
    .frame_number (rsp.data.frame_number)
);
